FILE: hw/rtl/les_pkg.sv
// Package for the LED effect sequencer: sizes, request, effect and mode codes,
// and the command struct passed from the controller to the datapath.
// No dependencies.
`default_nettype none

package les_pkg;

	localparam int NUM_LEDS = 8;
	localparam int LED_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int OUT_W    = 8;
	localparam int PERIOD_W = 10;
	localparam int RATE_W   = 15;
	localparam int AMT_W    = 15;
	localparam int CNT_W    = 17;

	// Largest blink count; larger requests saturate here
	localparam logic [AMT_W-1:0] COUNT_MAX = 15'd16383;

	typedef enum logic [1:0] {
		REQ_TICK      = 2'd0,
		REQ_SET       = 2'd1,
		REQ_SOFT_OFF  = 2'd2,
		REQ_FORCE_OFF = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		EFF_ON          = 3'd0,
		EFF_BLINK_EVER  = 3'd1,
		EFF_BLINK_TIME  = 3'd2,
		EFF_BLINK_COUNT = 3'd3,
		EFF_PULSE       = 3'd4
	} effect_t;

	typedef enum logic [2:0] {
		MODE_OFF         = 3'd0,
		MODE_ON          = 3'd1,
		MODE_BLINK_EVER  = 3'd2,
		MODE_BLINK_TIME  = 3'd3,
		MODE_BLINK_COUNT = 3'd4,
		MODE_PULSE       = 3'd5
	} mode_t;

	typedef struct packed {
		logic             latch;   // capture the request payload
		logic             step;    // update one LED entry
		logic             report;  // capture pins and busy mask
		logic [LED_W-1:0] led;     // LED entry to update
	} cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/les_ctrl.sv
// Controller of the LED effect sequencer: accepts requests and walks the LED
// entries one per cycle. Depends on les_pkg.
`default_nettype none

module les_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [1:0]             req_type,
	input  wire logic [2:0]             led_index,
	input  wire logic                   all_leds,
	output logic                        busy,
	output logic                        done,
	output les_pkg::cmd_t               cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_REPORT
	} state_t;

	localparam logic [les_pkg::LED_W-1:0] LAST_LED = les_pkg::LED_W'(les_pkg::NUM_LEDS - 1);

	state_t                    state_q;
	logic [les_pkg::LED_W-1:0] led_q;
	logic                      single_q;
	logic                      done_q;
	logic                      accept;
	logic                      walk_all;
	logic                      idx_ok;

	assign accept   = start && (state_q == ST_IDLE);
	assign walk_all = (req_type == les_pkg::REQ_TICK) || all_leds;
	assign idx_ok   = 32'(led_index) < les_pkg::NUM_LEDS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			led_q    <= '0;
			single_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (walk_all) begin
							led_q    <= '0;
							single_q <= 1'b0;
							state_q  <= ST_RUN;
						end else if (idx_ok) begin
							led_q    <= les_pkg::LED_W'(led_index);
							single_q <= 1'b1;
							state_q  <= ST_RUN;
						end else begin
							// out-of-range LED: drop the command, report only
							state_q <= ST_REPORT;
						end
					end
				end
				ST_RUN: begin
					if (single_q || (led_q == LAST_LED)) begin
						state_q <= ST_REPORT;
					end else begin
						led_q <= led_q + 1'b1;
					end
				end
				ST_REPORT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign cmd.latch  = accept;
	assign cmd.step   = (state_q == ST_RUN);
	assign cmd.report = (state_q == ST_REPORT);
	assign cmd.led    = led_q;

`ifndef NO_ASSERTIONS
	a_done_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_REPORT))
		else $error("result strobe without a report cycle");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	a_walk_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !single_q && led_q != LAST_LED) |=>
		(state_q == ST_RUN && led_q == les_pkg::LED_W'($past(led_q) + 1'b1)))
		else $error("LED walk skipped or stalled");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/les_datapath.sv
// Datapath of the LED effect sequencer: per-LED state, the one-entry update
// logic, the tick period register and the result registers. Depends on les_pkg.
`default_nettype none

module les_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire les_pkg::cmd_t                   cmd,
	input  wire logic [1:0]                      req_type,
	input  wire logic [2:0]                      effect,
	input  wire logic [les_pkg::RATE_W-1:0]      rate_ms,
	input  wire logic [les_pkg::AMT_W-1:0]       amount,
	input  wire logic                            cfg_we,
	input  wire logic [les_pkg::PERIOD_W-1:0]    cfg_data,
	output logic      [les_pkg::OUT_W-1:0]       led_pins,
	output logic      [les_pkg::OUT_W-1:0]       busy_mask
);

	localparam int N = les_pkg::NUM_LEDS;

	logic [les_pkg::PERIOD_W-1:0]   period_q;
	logic [1:0]                     req_q;
	logic [2:0]                     eff_q;
	logic [les_pkg::RATE_W-1:0]     rate_q;
	logic [les_pkg::AMT_W-1:0]      amt_q;

	les_pkg::mode_t                 req_mode_q   [N];
	les_pkg::mode_t                 shown_mode_q [N];
	logic signed [les_pkg::CNT_W-1:0] tgl_cd_q   [N];
	logic [les_pkg::RATE_W-1:0]     half_per_q   [N];
	logic signed [les_pkg::CNT_W-1:0] eff_rem_q  [N];
	logic signed [les_pkg::CNT_W-1:0] pulse_rem_q[N];
	logic [N-1:0]                   pin_q;

	les_pkg::mode_t                 n_req, n_shown;
	logic signed [les_pkg::CNT_W-1:0] n_cd, n_eff, n_pulse;
	logic [les_pkg::RATE_W-1:0]     n_hp;
	logic                           n_pin;

	logic [les_pkg::OUT_W-1:0]      pins_vec, busy_vec;
	logic [les_pkg::OUT_W-1:0]      led_pins_q, busy_mask_q;

	// Update of the addressed entry
	always_comb begin
		logic signed [les_pkg::CNT_W-1:0] per;
		logic [les_pkg::AMT_W-1:0]        cnt;
		logic                             blink;
		logic                             dec_cnt;
		les_pkg::mode_t                   bmode;
		per     = $signed({{(les_pkg::CNT_W - les_pkg::PERIOD_W){1'b0}}, period_q});
		cnt     = (amt_q > les_pkg::COUNT_MAX) ? les_pkg::COUNT_MAX : amt_q;
		blink   = 1'b0;
		dec_cnt = 1'b0;
		bmode   = les_pkg::MODE_OFF;
		n_req   = req_mode_q[cmd.led];
		n_shown = shown_mode_q[cmd.led];
		n_cd    = tgl_cd_q[cmd.led];
		n_hp    = half_per_q[cmd.led];
		n_eff   = eff_rem_q[cmd.led];
		n_pulse = pulse_rem_q[cmd.led];
		n_pin   = pin_q[cmd.led];
		case (req_q)
			les_pkg::REQ_TICK: begin
				case (n_req)
					les_pkg::MODE_ON: begin
						n_pin   = 1'b1;
						n_shown = les_pkg::MODE_ON;
					end
					les_pkg::MODE_BLINK_EVER: begin
						blink = 1'b1;
						bmode = les_pkg::MODE_BLINK_EVER;
					end
					les_pkg::MODE_BLINK_TIME: begin
						if (n_eff <= 0) begin
							n_pin   = 1'b0;
							n_req   = les_pkg::MODE_OFF;
							n_shown = les_pkg::MODE_OFF;
						end else begin
							n_eff = n_eff - per;
							blink = 1'b1;
							bmode = les_pkg::MODE_BLINK_TIME;
						end
					end
					les_pkg::MODE_BLINK_COUNT: begin
						if (n_eff <= 0) begin
							n_pin   = 1'b0;
							n_req   = les_pkg::MODE_OFF;
							n_shown = les_pkg::MODE_OFF;
						end else begin
							blink   = 1'b1;
							dec_cnt = 1'b1;
							bmode   = les_pkg::MODE_BLINK_COUNT;
						end
					end
					les_pkg::MODE_PULSE: begin
						if (n_pulse <= 0) begin
							n_pin   = 1'b0;
							n_req   = les_pkg::MODE_OFF;
							n_shown = les_pkg::MODE_OFF;
						end else begin
							n_pin   = 1'b1;
							n_shown = les_pkg::MODE_PULSE;
							n_pulse = n_pulse - per;
						end
					end
					default: begin
						n_pin   = 1'b0;
						n_shown = les_pkg::MODE_OFF;
					end
				endcase
				if (blink) begin
					if (n_cd <= 0) begin
						n_pin   = ~n_pin;
						n_shown = bmode;
						n_cd    = $signed({2'b00, n_hp});
						if (dec_cnt) begin
							n_eff = n_eff - 17'sd1;
						end
					end
					n_cd = n_cd - per;
				end
			end
			les_pkg::REQ_SET: begin
				case (eff_q)
					les_pkg::EFF_ON: begin
						n_req = les_pkg::MODE_ON;
					end
					les_pkg::EFF_BLINK_EVER: begin
						n_req = les_pkg::MODE_BLINK_EVER;
						n_hp  = rate_q;
					end
					les_pkg::EFF_BLINK_TIME: begin
						n_req = les_pkg::MODE_BLINK_TIME;
						n_hp  = rate_q;
						n_eff = $signed({2'b00, amt_q});
					end
					les_pkg::EFF_BLINK_COUNT: begin
						n_req = les_pkg::MODE_BLINK_COUNT;
						n_hp  = rate_q;
						n_eff = $signed({1'b0, cnt, 1'b0});
					end
					les_pkg::EFF_PULSE: begin
						n_req   = les_pkg::MODE_PULSE;
						n_pulse = $signed({2'b00, amt_q});
					end
					default: begin
					end
				endcase
			end
			les_pkg::REQ_SOFT_OFF: begin
				if (n_req == les_pkg::MODE_ON || n_req == les_pkg::MODE_BLINK_EVER) begin
					n_req = les_pkg::MODE_OFF;
					n_cd  = '0;
				end
			end
			default: begin
				n_req = les_pkg::MODE_OFF;
				n_cd  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= les_pkg::PERIOD_W'(1);
			for (int i = 0; i < N; i++) begin
				req_mode_q[i]   <= les_pkg::MODE_OFF;
				shown_mode_q[i] <= les_pkg::MODE_OFF;
				tgl_cd_q[i]     <= '0;
				half_per_q[i]   <= '0;
				eff_rem_q[i]    <= '0;
				pulse_rem_q[i]  <= '0;
			end
			pin_q <= '0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_data;
			end
			if (cmd.step) begin
				req_mode_q[cmd.led]   <= n_req;
				shown_mode_q[cmd.led] <= n_shown;
				tgl_cd_q[cmd.led]     <= n_cd;
				half_per_q[cmd.led]   <= n_hp;
				eff_rem_q[cmd.led]    <= n_eff;
				pulse_rem_q[cmd.led]  <= n_pulse;
				pin_q[cmd.led]        <= n_pin;
			end
		end
	end

	// Request payload, held for the walk
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q  <= req_type;
			eff_q  <= effect;
			rate_q <= rate_ms;
			amt_q  <= amount;
		end
	end

	for (genvar g = 0; g < les_pkg::OUT_W; g++) begin : g_out
		if (g < N) begin : g_led
			assign pins_vec[g] = pin_q[g];
			assign busy_vec[g] = (req_mode_q[g] != les_pkg::MODE_OFF);
		end else begin : g_pad
			assign pins_vec[g] = 1'b0;
			assign busy_vec[g] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_pins_q  <= '0;
			busy_mask_q <= '0;
		end else if (cmd.report) begin
			led_pins_q  <= pins_vec;
			busy_mask_q <= busy_vec;
		end
	end

	assign led_pins  = led_pins_q;
	assign busy_mask = busy_mask_q;

`ifndef NO_ASSERTIONS
	a_finished_led_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && req_q == les_pkg::REQ_TICK && req_mode_q[cmd.led] != les_pkg::MODE_OFF
		 && n_req == les_pkg::MODE_OFF) |-> (n_pin == 1'b0))
		else $error("finished effect left its pin lit");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cmd.report) |-> $stable(led_pins_q))
		else $error("pins changed outside a report cycle");

	a_single_step_target: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && req_q == les_pkg::REQ_FORCE_OFF) |=>
		(req_mode_q[$past(cmd.led)] == les_pkg::MODE_OFF))
		else $error("force off did not stop the LED");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/led_effect_sequencer.sv
// LED effect sequencer top level: request port, configuration port, controller
// and datapath. Depends on les_pkg, les_ctrl and les_datapath.
//
// A tick or an all-LED command walks every LED entry in turn, then reports; a
// single-LED command updates only its own entry, and one for an out-of-range
// LED goes straight to the report. One LED entry is updated per cycle, so the
// walk over the LED state sets the rate; busy stays high until the report
// cycle, and the next request may be taken in the cycle that done is shown.
// Reset (arst_n low) clears all LED effects, pins and countdowns, sets the tick
// period to 1 ms and drops any request in flight. The receiver cannot stall.
`default_nettype none

module led_effect_sequencer (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request port
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      req_type,
	input  wire logic [2:0]                      led_index,
	input  wire logic                            all_leds,
	input  wire logic [2:0]                      effect,
	input  wire logic [les_pkg::RATE_W-1:0]      rate_ms,
	input  wire logic [les_pkg::AMT_W-1:0]       amount,
	// result port: one strobe per request
	output logic                                 done,
	output logic      [les_pkg::OUT_W-1:0]       led_pins,
	output logic      [les_pkg::OUT_W-1:0]       busy_mask,
	// configuration port: tick period in ms
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [les_pkg::PERIOD_W-1:0]    cfg_data
);

	les_pkg::cmd_t cmd;
	logic          cfg_we;

	// Always take configuration writes; the period is only used during a tick walk
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Sequence the walk over the LED entries
	les_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.led_index (led_index),
		.all_leds  (all_leds),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	// Hold the LED state and advance one entry per step
	les_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_type  (req_type),
		.effect    (effect),
		.rate_ms   (rate_ms),
		.amount    (amount),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.led_pins  (led_pins),
		.busy_mask (busy_mask)
	);

endmodule

`default_nettype wire

FILE: test/les_checker.sv
// Checker for the LED effect sequencer: watches the request, result and period
// channels, predicts pins and busy mask per request and compares them.
// Depends on les_pkg.
module les_checker
	import les_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic [1:0]          req_type,
	input  wire logic [2:0]          led_index,
	input  wire logic                all_leds,
	input  wire logic [2:0]          effect,
	input  wire logic [RATE_W-1:0]   rate_ms,
	input  wire logic [AMT_W-1:0]    amount,
	input  wire logic                done,
	input  wire logic [OUT_W-1:0]    led_pins,
	input  wire logic [OUT_W-1:0]    busy_mask,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [PERIOD_W-1:0] cfg_data,
	output int                       mismatches,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [OUT_W-1:0] pins;
		logic [OUT_W-1:0] busy;
	} led_status_t;

	mode_t                   want_mode  [NUM_LEDS];
	mode_t                   shown_mode [NUM_LEDS];
	logic signed [CNT_W-1:0] toggle_left[NUM_LEDS];
	logic        [RATE_W-1:0] half_per  [NUM_LEDS];
	logic signed [CNT_W-1:0] run_left   [NUM_LEDS];
	logic signed [CNT_W-1:0] pulse_left [NUM_LEDS];
	logic [NUM_LEDS-1:0]     pin_lvl;
	logic [PERIOD_W-1:0]     tick_ms;
	led_status_t             status_q[$];
	int                      errs;

	task automatic finish_led(int i);
		pin_lvl[i] = 1'b0;
		want_mode[i] = MODE_OFF;
		shown_mode[i] = MODE_OFF;
	endtask

	// Flip the pin and reload the half period once the countdown has run out.
	task automatic toggle_step(int i, logic signed [CNT_W-1:0] per, mode_t m, bit counted);
		if (toggle_left[i] <= 0) begin
			pin_lvl[i] = ~pin_lvl[i];
			shown_mode[i] = m;
			toggle_left[i] = $signed({{(CNT_W-RATE_W){1'b0}}, half_per[i]});
			if (counted)
				run_left[i] = run_left[i] - $signed(CNT_W'(1));
		end
		toggle_left[i] = toggle_left[i] - per;
	endtask

	task automatic apply_request(int i, req_t rq, logic [2:0] eff, logic [RATE_W-1:0] rate,
			logic [AMT_W-1:0] amt);
		logic [AMT_W-1:0] blinks;
		case (rq)
		REQ_SET: begin
			case (eff)
			EFF_ON: want_mode[i] = MODE_ON;
			EFF_BLINK_EVER: begin
				want_mode[i] = MODE_BLINK_EVER;
				half_per[i] = rate;
			end
			EFF_BLINK_TIME: begin
				want_mode[i] = MODE_BLINK_TIME;
				half_per[i] = rate;
				run_left[i] = $signed({{(CNT_W-AMT_W){1'b0}}, amt});
			end
			EFF_BLINK_COUNT: begin
				blinks = (amt > COUNT_MAX) ? COUNT_MAX : amt;
				want_mode[i] = MODE_BLINK_COUNT;
				half_per[i] = rate;
				// two toggles per blink
				run_left[i] = $signed({{(CNT_W-AMT_W-1){1'b0}}, blinks, 1'b0});
			end
			EFF_PULSE: begin
				want_mode[i] = MODE_PULSE;
				pulse_left[i] = $signed({{(CNT_W-AMT_W){1'b0}}, amt});
			end
			default: ;
			endcase
		end
		REQ_SOFT_OFF: begin
			if (want_mode[i] == MODE_ON || want_mode[i] == MODE_BLINK_EVER) begin
				want_mode[i] = MODE_OFF;
				toggle_left[i] = '0;
			end
		end
		REQ_FORCE_OFF: begin
			want_mode[i] = MODE_OFF;
			toggle_left[i] = '0;
		end
		default: ;
		endcase
	endtask

	// Advance the LED state by one request and queue the status it leaves.
	task automatic step_leds(req_t rq, logic [2:0] idx, logic whole, logic [2:0] eff,
			logic [RATE_W-1:0] rate, logic [AMT_W-1:0] amt);
		logic signed [CNT_W-1:0] per;
		led_status_t s;
		per = $signed({{(CNT_W-PERIOD_W){1'b0}}, tick_ms});
		if (rq == REQ_TICK) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				case (want_mode[i])
				MODE_ON: begin
					if (shown_mode[i] != MODE_ON) begin
						pin_lvl[i] = 1'b1;
						shown_mode[i] = MODE_ON;
					end
				end
				MODE_BLINK_EVER: toggle_step(i, per, MODE_BLINK_EVER, 1'b0);
				MODE_BLINK_TIME: begin
					if (run_left[i] <= 0)
						finish_led(i);
					else begin
						run_left[i] = run_left[i] - per;
						toggle_step(i, per, MODE_BLINK_TIME, 1'b0);
					end
				end
				MODE_BLINK_COUNT: begin
					if (run_left[i] <= 0)
						finish_led(i);
					else
						toggle_step(i, per, MODE_BLINK_COUNT, 1'b1);
				end
				MODE_PULSE: begin
					if (pulse_left[i] <= 0)
						finish_led(i);
					else begin
						if (shown_mode[i] != MODE_PULSE) begin
							pin_lvl[i] = 1'b1;
							shown_mode[i] = MODE_PULSE;
						end
						pulse_left[i] = pulse_left[i] - per;
					end
				end
				default: begin
					if (shown_mode[i] != MODE_OFF) begin
						pin_lvl[i] = 1'b0;
						shown_mode[i] = MODE_OFF;
					end
				end
				endcase
			end
		end else if (whole) begin
			for (int i = 0; i < NUM_LEDS; i++)
				apply_request(i, rq, eff, rate, amt);
		end else if (int'(idx) < NUM_LEDS) begin
			apply_request(int'(idx), rq, eff, rate, amt);
		end
		s = '0;
		for (int i = 0; i < NUM_LEDS && i < OUT_W; i++) begin
			s.pins[i] = pin_lvl[i];
			s.busy[i] = (want_mode[i] != MODE_OFF);
		end
		status_q.push_back(s);
	endtask

	always @(posedge clk or negedge arst_n) begin
		led_status_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				want_mode[i] = MODE_OFF;
				shown_mode[i] = MODE_OFF;
				toggle_left[i] = '0;
				half_per[i] = '0;
				run_left[i] = '0;
				pulse_left[i] = '0;
			end
			pin_lvl = '0;
			tick_ms = PERIOD_W'(1);
			status_q.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (status_q.size() == 0) begin
					$display("%0t: result with none expected: pins %02h busy %02h",
						$time, led_pins, busy_mask);
					errs++;
				end else begin
					want = status_q.pop_front();
					if (led_pins !== want.pins) begin
						$display("%0t: led_pins expected %02h got %02h",
							$time, want.pins, led_pins);
						errs++;
					end
					if (busy_mask !== want.busy) begin
						$display("%0t: busy_mask expected %02h got %02h",
							$time, want.busy, busy_mask);
						errs++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				tick_ms = cfg_data;
			if (start && !busy)
				step_leds(req_t'(req_type), led_index, all_leds, effect, rate_ms, amount);
			mismatches <= errs;
			outstanding <= status_q.size();
		end
	end

endmodule

FILE: test/tb.sv
// Top of the LED effect sequencer bench: clock, reset, request and period
// stimulus, and the verdict. Depends on les_pkg, led_effect_sequencer and
// les_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import les_pkg::*;

	// generous ceiling, well above the slowest legal run
	localparam int MAX_CYCLES = 250000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          req_type = '0;
	logic [2:0]          led_index = '0;
	logic                all_leds = 1'b0;
	logic [2:0]          effect = '0;
	logic [RATE_W-1:0]   rate_ms = '0;
	logic [AMT_W-1:0]    amount = '0;
	logic                cfg_valid = 1'b0;
	logic [PERIOD_W-1:0] cfg_data = '0;
	logic                busy, done, cfg_ready;
	logic [OUT_W-1:0]    led_pins, busy_mask;
	int                  mismatches, outstanding;
	int                  cycle_count = 0;

	led_effect_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.led_index (led_index),
		.all_leds  (all_leds),
		.effect    (effect),
		.rate_ms   (rate_ms),
		.amount    (amount),
		.done      (done),
		.led_pins  (led_pins),
		.busy_mask (busy_mask),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// The checker sees exactly what the block sees and does all the predicting;
	// this module only produces traffic and reads back the two counters.
	les_checker check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.led_index   (led_index),
		.all_leds    (all_leds),
		.effect      (effect),
		.rate_ms     (rate_ms),
		.amount      (amount),
		.done        (done),
		.led_pins    (led_pins),
		.busy_mask   (busy_mask),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run: a lost result or a stuck handshake ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Present one request and hold it until the block takes it. Busy is read
	// straight after the edge, so it is the value the block saw at that edge.
	// Afterwards, idle the request line for a while now and then; when no idle
	// is drawn, start stays high and the next request follows back to back.
	task automatic issue(req_t rq, logic [2:0] led, logic whole, logic [2:0] eff,
			logic [RATE_W-1:0] rate, logic [AMT_W-1:0] amt, bit may_idle);
		req_type <= rq;
		led_index <= led;
		all_leds <= whole;
		effect <= eff;
		rate_ms <= rate;
		amount <= amt;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		if (may_idle && $urandom_range(0, 99) < 37) begin
			start <= 1'b0;
			// gaps up to a little over the walk length land on every phase
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Drop start and hold off until every predicted status has come back.
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Write the tick period with the block idle.
	task automatic set_period(logic [PERIOD_W-1:0] ms);
		drain();
		repeat ($urandom_range(0, 3)) @(posedge clk);
		cfg_data <= ms;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
	endtask

	// Mostly ticks, so effects actually run their course; rates and amounts are
	// scaled to the tick period so that timed effects finish within a phase,
	// with an occasional request over the full field range.
	task automatic random_request(logic [PERIOD_W-1:0] ms, bit may_idle);
		int               pick, scale;
		req_t             rq;
		logic [2:0]       eff;
		logic [RATE_W-1:0] rate;
		logic [AMT_W-1:0] amt;
		scale = (ms == '0) ? 1 : int'(ms);
		pick = $urandom_range(0, 99);
		if (pick < 55)
			rq = REQ_TICK;
		else if (pick < 82)
			rq = REQ_SET;
		else if (pick < 91)
			rq = REQ_SOFT_OFF;
		else
			rq = REQ_FORCE_OFF;
		// unused effect codes now and then; the block must ignore them
		if ($urandom_range(0, 9) == 0)
			eff = 3'($urandom_range(5, 7));
		else
			eff = 3'($urandom_range(0, 4));
		if ($urandom_range(0, 7) == 0) begin
			rate = RATE_W'($urandom);
			amt = AMT_W'($urandom);
		end else begin
			rate = RATE_W'(scale * $urandom_range(0, 4));
			amt = AMT_W'(scale * $urandom_range(0, 24));
		end
		issue(rq, 3'($urandom), $urandom_range(0, 4) == 0, eff, rate, amt, may_idle);
	endtask

	initial begin
		logic [PERIOD_W-1:0] period_ms;
		int                  sent;
		period_ms = PERIOD_W'(1);
		sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opener at the reset period of 1 ms.
		issue(REQ_TICK, 3'd0, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_SET, 3'd0, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_SET, 3'd1, 1'b0, EFF_BLINK_EVER, 15'd2, 15'd0, 1'b1);
		issue(REQ_SET, 3'd2, 1'b0, EFF_BLINK_TIME, 15'd1, 15'd4, 1'b1);
		// blink count far above the ceiling: saturates
		issue(REQ_SET, 3'd3, 1'b0, EFF_BLINK_COUNT, 15'd0, 15'h7fff, 1'b1);
		issue(REQ_SET, 3'd4, 1'b0, EFF_PULSE, 15'd0, 15'd3, 1'b1);
		// unknown effect codes, single and broadcast: no change
		issue(REQ_SET, 3'd5, 1'b0, 3'd7, 15'h7fff, 15'h7fff, 1'b1);
		issue(REQ_SET, 3'd6, 1'b1, 3'd5, 15'h7fff, 15'h7fff, 1'b1);
		issue(REQ_SET, 3'd7, 1'b0, EFF_BLINK_EVER, 15'h7fff, 15'h7fff, 1'b1);
		// ticks carry junk in the unused fields; enough to finish the pulse
		repeat (5) issue(REQ_TICK, 3'd7, 1'b1, 3'd7, 15'h7fff, 15'h7fff, 1'b1);
		// soft off leaves a timed blink alone but stops an endless one
		issue(REQ_SOFT_OFF, 3'd2, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_SOFT_OFF, 3'd1, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_FORCE_OFF, 3'd3, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_TICK, 3'd0, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_SET, 3'd0, 1'b1, EFF_ON, 15'h7fff, 15'h7fff, 1'b1);
		issue(REQ_TICK, 3'd0, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_SOFT_OFF, 3'd0, 1'b1, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_FORCE_OFF, 3'd0, 1'b1, EFF_ON, 15'd0, 15'd0, 1'b1);
		issue(REQ_TICK, 3'd0, 1'b0, EFF_ON, 15'd0, 15'd0, 1'b1);

		// Random phases, each at its own tick period: the extremes 0, 1, 1000
		// and 1023 among them. Phase 0 keeps the reset value.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph != 0) begin
				case (ph)
				1: period_ms = 10'd1000;
				2: period_ms = 10'd3;
				3: period_ms = 10'd0;
				4: period_ms = 10'd1023;
				5: period_ms = 10'd1;
				6: period_ms = PERIOD_W'($urandom_range(2, 999));
				default: period_ms = 10'd2;
				endcase
				set_period(period_ms);
			end
			for (int k = 0; k < 110; k++) begin
				// one long stretch runs flat out with no random idle gaps
				random_request(period_ms, !(sent >= 250 && sent < 400));
				sent++;
				// now and then let the block empty out completely
				if ($urandom_range(0, 99) == 0)
					drain();
			end
		end

		drain();
		// walk length plus margin, so a stray late result is still caught
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
